### sv/qte_pkg.sv
// Shared constants, types and the arctangent table of the quaternion to Euler
// angle unit. No dependencies; every other file of the block uses this package.
package qte_pkg;

  // Number of CORDIC micro-rotations; meaningful from 8 to 24.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int ITER         = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Operand width of the atan2 inputs, CORDIC datapath width and angle width.
  localparam int OPW = 34;
  localparam int CW  = 45;
  localparam int ZW  = 35;
  localparam int AW  = 25;

  // Quotient bits of the arcsine ratio and result bits of the square root.
  localparam int QBITS = 31;

  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [31:0] DEG_RECIP = 32'd3845054675;  // 180 * 2^56 / pi(Q30), floored
  localparam logic [23:0] DEG_SCALE = 24'd11796480;    // 180 * 2^16

  // Register stages of one atan2 lane: normalize (3), pre-rotation, the
  // micro-rotations and five output stages.
  localparam int LANE_DEPTH = 4 + ITER + 5;

  // Data that travels beside the arcsine ratio and square root pipeline.
  typedef struct packed {
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic                  s_neg;
    logic                  zero;
  } qte_side_t;

  // atan(2^-i) in Q30, rounded to nearest.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/qte_if.sv
// Valid/ready channel interfaces of the quaternion to Euler angle unit.
// Depends on qte_pkg for the angle width.
interface qte_quat_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  q_real;
  logic signed [15:0]  q_i;
  logic signed [15:0]  q_j;
  logic signed [15:0]  q_k;

  modport source (output valid, q_real, q_i, q_j, q_k, input ready);
  modport sink   (input valid, q_real, q_i, q_j, q_k, output ready);
endinterface

interface qte_euler_if;
  logic                          valid;
  logic                          ready;
  logic signed [qte_pkg::AW-1:0] yaw_angle;
  logic signed [qte_pkg::AW-1:0] pitch_angle;
  logic signed [qte_pkg::AW-1:0] roll_angle;
  logic                          zero_input;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, zero_input, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, zero_input, output ready);
endinterface

### sv/qte_pitch.sv
// Arcsine operands of the pitch angle: pipelined ratio divider, square and
// pipelined integer square root. Depends on qte_pkg.
module qte_pitch (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [qte_pkg::OPW-1:0] s,
  input  logic        [32:0]             n,
  input  qte_pkg::qte_side_t             side_in,
  output logic                           out_valid,
  output logic signed [qte_pkg::OPW-1:0] a,
  output logic signed [qte_pkg::OPW-1:0] c,
  output qte_pkg::qte_side_t             side_out
);

  localparam int QB = qte_pkg::QBITS;
  localparam int RW = 34;
  localparam int SW = 62;

  // Divider: remainder, divisor and quotient per stage.
  logic [RW-1:0]      drem  [0:QB];
  logic [32:0]        dn    [0:QB];
  logic [QB-1:0]      dq    [0:QB];
  qte_pkg::qte_side_t dside [0:QB];
  logic [QB:0]        dvalid;

  always_ff @(posedge clk) begin
    if (adv) begin
      drem[0]  <= RW'(s[qte_pkg::OPW-1] ? -s : s);
      dn[0]    <= n;
      dq[0]    <= '0;
      dside[0] <= side_in;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    logic          ge;
    logic [RW-1:0] rsub;
    assign ge   = drem[g] >= RW'(dn[g]);
    assign rsub = ge ? drem[g] - RW'(dn[g]) : drem[g];
    always_ff @(posedge clk) begin
      if (adv) begin
        drem[g+1]  <= {rsub[RW-2:0], 1'b0};
        dn[g+1]    <= dn[g];
        dq[g+1]    <= {dq[g][QB-2:0], ge};
        dside[g+1] <= dside[g];
      end
    end
  end

  // The ratio never exceeds one; the limit only guards the square root.
  logic [QB-1:0]      amc_next;
  logic [QB-1:0]      amc;
  logic [SW-1:0]      sq;
  qte_pkg::qte_side_t qside;
  logic               qvalid;

  assign amc_next = (dq[QB] > (QB'(1) << 30)) ? (QB'(1) << 30) : dq[QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      amc   <= amc_next;
      sq    <= SW'(amc_next) * SW'(amc_next);
      qside <= dside[QB];
    end
  end

  // Square root, one result bit per stage, most significant first.
  logic [SW-1:0]      srem  [0:QB];
  logic [QB-1:0]      sres  [0:QB];
  logic [QB-1:0]      sam   [0:QB];
  qte_pkg::qte_side_t sside [0:QB];
  logic [QB:0]        svalid;

  always_ff @(posedge clk) begin
    if (adv) begin
      srem[0]  <= (SW'(1) << 60) - sq;
      sres[0]  <= '0;
      sam[0]   <= amc;
      sside[0] <= qside;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_sqrt
    localparam int B = QB - 1 - g;
    logic [SW-1:0] trial;
    logic          ge;
    assign trial = (SW'(sres[g]) << (B + 1)) + (SW'(1) << (2 * B));
    assign ge    = srem[g] >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        srem[g+1]  <= ge ? srem[g] - trial : srem[g];
        sres[g+1]  <= ge ? (sres[g] | (QB'(1) << B)) : sres[g];
        sam[g+1]   <= sam[g];
        sside[g+1] <= sside[g];
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
      qvalid <= 1'b0;
      svalid <= '0;
    end else if (adv) begin
      dvalid <= {dvalid[QB-1:0], in_valid};
      qvalid <= dvalid[QB];
      svalid <= {svalid[QB-1:0], qvalid};
    end
  end

  assign out_valid = svalid[QB];
  assign a         = sside[QB].s_neg ? -qte_pkg::OPW'(sam[QB]) : qte_pkg::OPW'(sam[QB]);
  assign c         = qte_pkg::OPW'(sres[QB]);
  assign side_out  = sside[QB];

endmodule

### sv/qte_atan_lane.sv
// One atan2 lane: leading-zero normalization, vectoring CORDIC and conversion
// of the Q30 angle to Q16 radians or degrees. Depends on qte_pkg.
module qte_atan_lane (
  input  logic                           clk,
  input  logic                           adv,
  input  logic                           degree_mode,
  input  logic signed [qte_pkg::OPW-1:0] x_in,
  input  logic signed [qte_pkg::OPW-1:0] y_in,
  input  logic                           force_zero,
  output logic signed [qte_pkg::AW-1:0]  angle
);

  localparam int OPW = qte_pkg::OPW;
  localparam int CW  = qte_pkg::CW;
  localparam int ZW  = qte_pkg::ZW;
  localparam int AW  = qte_pkg::AW;
  localparam int N   = qte_pkg::ITER;
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(qte_pkg::PI_Q30);
  localparam logic        [63:0]   HALF40 = 64'd1 << 39;

  // Magnitudes are merged by OR: the leading one of the OR is the leading
  // one of the larger magnitude.
  logic [OPW-1:0] ax, ay;
  assign ax = x_in[OPW-1] ? OPW'(-x_in) : OPW'(x_in);
  assign ay = y_in[OPW-1] ? OPW'(-y_in) : OPW'(y_in);

  logic signed [CW-1:0] x0, y0, x1, y1, x2, y2;
  logic        [CW-1:0] o0, o1, o2;
  logic                 zr0, zr1, zr2;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0  <= CW'(x_in);
      y0  <= CW'(y_in);
      o0  <= CW'(ax | ay);
      zr0 <= force_zero || ((ax | ay) == '0);
    end
  end

  logic signed [CW-1:0] x1_next, y1_next, x2_next, y2_next;
  logic        [CW-1:0] o1_next, o2_next;

  // Shift until the larger magnitude has its leading one at bit 40.
  always_comb begin
    x1_next = x0;
    y1_next = y0;
    o1_next = o0;
    if (o1_next < (CW'(1) << 9)) begin
      x1_next = x1_next <<< 32; y1_next = y1_next <<< 32; o1_next = o1_next << 32;
    end
    if (o1_next < (CW'(1) << 25)) begin
      x1_next = x1_next <<< 16; y1_next = y1_next <<< 16; o1_next = o1_next << 16;
    end
    if (o1_next < (CW'(1) << 33)) begin
      x1_next = x1_next <<< 8; y1_next = y1_next <<< 8; o1_next = o1_next << 8;
    end
  end

  always_comb begin
    x2_next = x1;
    y2_next = y1;
    o2_next = o1;
    if (o2_next < (CW'(1) << 37)) begin
      x2_next = x2_next <<< 4; y2_next = y2_next <<< 4; o2_next = o2_next << 4;
    end
    if (o2_next < (CW'(1) << 39)) begin
      x2_next = x2_next <<< 2; y2_next = y2_next <<< 2; o2_next = o2_next << 2;
    end
    if (o2_next < (CW'(1) << 40)) begin
      x2_next = x2_next <<< 1; y2_next = y2_next <<< 1; o2_next = o2_next << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1  <= x1_next;
      y1  <= y1_next;
      o1  <= o1_next;
      zr1 <= zr0;
      x2  <= x2_next;
      y2  <= y2_next;
      o2  <= o2_next;
      zr2 <= zr1;
    end
  end

  // Micro-rotation pipeline; entry 0 holds the vector after the half turn
  // that brings it into the right half plane.
  logic signed [CW-1:0] cx [0:N];
  logic signed [CW-1:0] cy [0:N];
  logic signed [ZW-1:0] cz [0:N];
  logic                 czero [0:N];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (x2[CW-1]) begin
        cx[0] <= -x2;
        cy[0] <= -y2;
        cz[0] <= y2[CW-1] ? -PI_Z : PI_Z;
      end else begin
        cx[0] <= x2;
        cy[0] <= y2;
        cz[0] <= '0;
      end
      czero[0] <= zr2 || (o2 == '0);
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] step;
    assign dx   = cy[g] >>> g;
    assign dy   = cx[g] >>> g;
    assign step = $signed(ZW'(qte_pkg::atan_q30(5'(g))));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy[g][CW-1]) begin
          cx[g+1] <= cx[g] + dx;
          cy[g+1] <= cy[g] - dy;
          cz[g+1] <= cz[g] + step;
        end else begin
          cx[g+1] <= cx[g] - dx;
          cy[g+1] <= cy[g] + dy;
          cz[g+1] <= cz[g] - step;
        end
        czero[g+1] <= czero[g];
      end
    end
  end

  // Output conversion: clamp to [-pi, pi], then round to Q16 radians or
  // multiply by the degree reciprocal and correct the estimate by one.
  logic signed [ZW-1:0] zc;
  always_comb begin
    if (czero[N]) begin
      zc = '0;
    end else if (cz[N] > PI_Z) begin
      zc = PI_Z;
    end else if (cz[N] < -PI_Z) begin
      zc = -PI_Z;
    end else begin
      zc = cz[N];
    end
  end

  logic [31:0]   o1_mag, o2_mag;
  logic          o1_neg, o2_neg, o3_neg, o4_neg;
  logic [63:0]   o2_prod;
  logic [AW-1:0] o2_rad, o3_rad, o4_rad;
  logic [AW-1:0] o3_est, o4_est;
  logic [55:0]   o3_p2, o4_p2;
  logic [56:0]   o4_p1;

  always_ff @(posedge clk) begin
    if (adv) begin
      o1_mag  <= 32'(zc[ZW-1] ? -zc : zc);
      o1_neg  <= zc[ZW-1];
      o2_prod <= 64'(o1_mag) * 64'(qte_pkg::DEG_RECIP);
      o2_mag  <= o1_mag;
      o2_neg  <= o1_neg;
      o2_rad  <= AW'((o1_mag + 32'd8192) >> 14);
      o3_est  <= AW'((o2_prod + HALF40) >> 40);
      o3_p2   <= 56'(o2_mag) * 56'(qte_pkg::DEG_SCALE);
      o3_neg  <= o2_neg;
      o3_rad  <= o2_rad;
      o4_p1   <= 57'(o3_est) * 57'(qte_pkg::PI_Q30);
      o4_est  <= o3_est;
      o4_p2   <= o3_p2;
      o4_neg  <= o3_neg;
      o4_rad  <= o3_rad;
    end
  end

  logic [58:0]   rem;
  logic [AW-1:0] deg, mag;
  assign rem = 59'(o4_p2) + 59'(qte_pkg::PI_Q30 >> 1) - 59'(o4_p1);

  always_comb begin
    if (rem[58]) begin
      deg = o4_est - 1'b1;
    end else if (rem >= 59'(qte_pkg::PI_Q30)) begin
      deg = o4_est + 1'b1;
    end else begin
      deg = o4_est;
    end
    mag = degree_mode ? deg : o4_rad;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle <= o4_neg ? -mag : mag;
    end
  end

endmodule

### sv/quaternion_to_euler_angles_unit.sv
// Top level of the quaternion to Euler angle (yaw, pitch, roll) unit.
// Depends on qte_pkg, qte_if, qte_pitch and qte_atan_lane.
//
// Usage:
// An item on the quat channel is one quaternion (q_real, q_i, q_j, q_k) in
// signed Q14. For each accepted item exactly one item leaves on the euler
// channel: yaw, pitch and roll in signed Q16, in radians or, when
// degree_mode is set, in degrees, plus zero_input for an all-zero quaternion
// (the angles are then zero).
// The unit is one pipeline that takes a new item in every cycle unless it
// stalls. Its depth is set by the bit-per-stage ratio divider and square root
// of the pitch path and by the CORDIC depth.
// Throughput is one item per clock while the receiver takes items.
// When the receiver stalls, the whole pipeline holds and quat.ready falls, so
// the item in the output register waits and nothing is lost or repeated.
// degree_mode is written through cfg_write/cfg_data while the unit is idle.
// Synchronous reset clears the valid bits of all stages and degree_mode.
module quaternion_to_euler_angles_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  qte_quat_if.sink           quat,
  qte_euler_if.source        euler
);

  localparam int OPW = qte_pkg::OPW;
  localparam int LD  = qte_pkg::LANE_DEPTH;

  logic degree_mode;
  logic adv;

  // Every stage moves when the output register is empty or being emptied.
  assign adv        = !euler.valid || euler.ready;
  assign quat.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_mode <= 1'b0;
    end else if (cfg_write) begin
      degree_mode <= cfg_data;
    end
  end

  // Stage one: the ten products of the rotation matrix terms, exact in Q28.
  logic signed [31:0] p_rr, p_ii, p_jj, p_kk, p_ij, p_kr, p_jk, p_ir, p_ik, p_jr;
  logic               p0_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rr <= 32'(quat.q_real) * 32'(quat.q_real);
      p_ii <= 32'(quat.q_i) * 32'(quat.q_i);
      p_jj <= 32'(quat.q_j) * 32'(quat.q_j);
      p_kk <= 32'(quat.q_k) * 32'(quat.q_k);
      p_ij <= 32'(quat.q_i) * 32'(quat.q_j);
      p_kr <= 32'(quat.q_k) * 32'(quat.q_real);
      p_jk <= 32'(quat.q_j) * 32'(quat.q_k);
      p_ir <= 32'(quat.q_i) * 32'(quat.q_real);
      p_ik <= 32'(quat.q_i) * 32'(quat.q_k);
      p_jr <= 32'(quat.q_j) * 32'(quat.q_real);
    end
  end

  // Stage two: squared norm, the two atan2 operand pairs and the arcsine
  // numerator.
  logic signed [OPW-1:0] n_sum;
  logic signed [OPW-1:0] s_next;
  qte_pkg::qte_side_t    side_next;
  qte_pkg::qte_side_t    p1_side;
  logic signed [OPW-1:0] p1_s;
  logic [32:0]           p1_n;
  logic                  p1_valid;

  assign s_next = (OPW'(p_jr) - OPW'(p_ik)) <<< 1;

  always_comb begin
    n_sum             = OPW'(p_rr) + OPW'(p_ii) + OPW'(p_jj) + OPW'(p_kk);
    side_next.yaw_y   = (OPW'(p_ij) + OPW'(p_kr)) <<< 1;
    side_next.yaw_x   = OPW'(p_rr) + OPW'(p_ii) - OPW'(p_jj) - OPW'(p_kk);
    side_next.roll_y  = (OPW'(p_jk) + OPW'(p_ir)) <<< 1;
    side_next.roll_x  = OPW'(p_rr) - OPW'(p_ii) - OPW'(p_jj) + OPW'(p_kk);
    side_next.s_neg   = s_next[OPW-1];
    side_next.zero    = (n_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side       <= side_next;
      p1_s          <= s_next;
      p1_n          <= n_sum[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
      p1_valid <= 1'b0;
    end else if (adv) begin
      p0_valid <= quat.valid;
      p1_valid <= p0_valid;
    end
  end

  // Arcsine ratio and its cosine; the yaw and roll operands ride alongside.
  logic                  pv;
  logic signed [OPW-1:0] pa, pc;
  qte_pkg::qte_side_t    ps;

  qte_pitch u_pitch (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p1_valid),
    .s         (p1_s),
    .n         (p1_n),
    .side_in   (p1_side),
    .out_valid (pv),
    .a         (pa),
    .c         (pc),
    .side_out  (ps)
  );

  // Three atan2 lanes in lockstep; their last register is the output register.
  qte_atan_lane u_yaw (
    .clk         (clk),
    .adv         (adv),
    .degree_mode (degree_mode),
    .x_in        (ps.yaw_x),
    .y_in        (ps.yaw_y),
    .force_zero  (ps.zero),
    .angle       (euler.yaw_angle)
  );

  qte_atan_lane u_pitch_lane (
    .clk         (clk),
    .adv         (adv),
    .degree_mode (degree_mode),
    .x_in        (pc),
    .y_in        (pa),
    .force_zero  (ps.zero),
    .angle       (euler.pitch_angle)
  );

  qte_atan_lane u_roll (
    .clk         (clk),
    .adv         (adv),
    .degree_mode (degree_mode),
    .x_in        (ps.roll_x),
    .y_in        (ps.roll_y),
    .force_zero  (ps.zero),
    .angle       (euler.roll_angle)
  );

  // Valid and zero flag follow the lanes stage by stage.
  logic [LD-1:0] lane_valid;
  logic [LD-1:0] lane_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= '0;
    end else if (adv) begin
      lane_valid <= {lane_valid[LD-2:0], pv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_zero <= {lane_zero[LD-2:0], ps.zero};
    end
  end

  assign euler.valid      = lane_valid[LD-1];
  assign euler.zero_input = lane_zero[LD-1];

endmodule
